FILE: design/jam_pkg.sv
// shared constants, register codes and configuration types for the joystick mapper
package jam_pkg;

  // default build parameters
  localparam int SAMPLES_PER_AVERAGE_DEF = 8;
  localparam int SAMPLE_FULL_SCALE_DEF   = 4095;

  // fixed field widths
  localparam int RAW_W     = 12;
  localparam int OFFSET_W  = 13;
  localparam int POS_W     = 12;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // offset added to the raw sample can reach this much at most
  localparam int CAL_LIMIT = 2 * 4095;

  // percent arithmetic: ((1000*dist/span)+5)/10, saturating at 100
  localparam int PCT_SCALE   = 1000;
  localparam int PCT_SCALE_W = 10;
  localparam int QSAT_W      = 10;
  localparam int QSAT_MAX    = 995;
  localparam int ROUND_ADD   = 5;
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;
  localparam int DIV10_W     = 18;

  // queue between front and back
  localparam int Q_DEPTH = 2;

  // axis codes
  localparam logic AXIS_LEFT  = 1'b0;
  localparam logic AXIS_RIGHT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_CENTER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_RIGHT_END  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_LEFT_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CENTER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_FRONT_END = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BACK_END  = 3'd6;

  // axis geometry seen by the back end
  typedef struct packed {
    logic [POS_W-1:0] left_center;
    logic [POS_W-1:0] left_right_end;
    logic [POS_W-1:0] left_left_end;
    logic [POS_W-1:0] right_center;
    logic [POS_W-1:0] right_front_end;
    logic [POS_W-1:0] right_back_end;
  } geom_t;

endpackage

FILE: design/jam_front.sv
// front end: calibrates samples and accumulates per-axis sums
module jam_front import jam_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF,
  parameter int SAMPLE_FULL_SCALE   = SAMPLE_FULL_SCALE_DEF,
  parameter int CAL_W               = 12,
  parameter int SUM_W               = 15
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_axis_i,
  input  logic [RAW_W-1:0]           in_raw_i,
  output logic                       in_ready_o,
  input  logic signed [OFFSET_W-1:0] offset_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output logic [SUM_W:0]             push_data_o
);

  localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam int CMP_W = 18;

  logic [SUM_W-1:0] sum_q [2];
  logic [SUM_W-1:0] sum_d;
  logic [CNT_W-1:0] cnt_q [2];
  logic             accept;
  logic             last;
  logic signed [CMP_W-1:0] cal_s;
  logic [CAL_W-1:0] cal;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // offset and clamp to 0..full scale, full-scale raw sticks
  assign cal_s = $signed(CMP_W'(in_raw_i)) + CMP_W'(offset_i);
  always_comb begin
    if (cal_s < 0) begin
      cal = '0;
    end else if (cal_s > $signed(CMP_W'(SAMPLE_FULL_SCALE)) ||
                 CMP_W'(in_raw_i) == CMP_W'(SAMPLE_FULL_SCALE)) begin
      cal = CAL_W'(SAMPLE_FULL_SCALE);
    end else begin
      cal = cal_s[CAL_W-1:0];
    end
  end

  assign sum_d = sum_q[in_axis_i] + SUM_W'(cal);
  assign last  = cnt_q[in_axis_i] == CNT_W'(SAMPLES_PER_AVERAGE - 1);

  // completed sum goes to the queue
  assign push_o      = accept && last;
  assign push_data_o = {in_axis_i, sum_d};

  // per-axis accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
    end else if (accept) begin
      if (last) begin
        sum_q[in_axis_i] <= '0;
        cnt_q[in_axis_i] <= '0;
      end else begin
        sum_q[in_axis_i] <= sum_d;
        cnt_q[in_axis_i] <= cnt_q[in_axis_i] + CNT_W'(1);
      end
    end
  end

endmodule

FILE: design/jam_queue.sv
// short queue of completed sums between front and back
module jam_queue import jam_pkg::*; #(
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o     = cnt_q == CNT_W'(Q_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

FILE: design/jam_div.sv
// restoring serial divider, one quotient bit per cycle
module jam_div import jam_pkg::*; #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W:0]    trial;
  logic              fits;

  // shift in next dividend bit and try subtracting
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  // data path
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/jam_back.sv
// back end: average, side selection, percentage and output register
module jam_back import jam_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF,
  parameter int CAL_W               = 12,
  parameter int SUM_W               = 15
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  geom_t          geom_i,
  input  logic           q_empty_i,
  input  logic [SUM_W:0] q_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           out_axis_o,
  output logic           out_dir_o,
  output logic [PCT_W-1:0] out_pct_o,
  output logic           out_fault_o
);

  localparam int DIST_W = (CAL_W > POS_W) ? CAL_W : POS_W;
  localparam int PROD_W = DIST_W + PCT_SCALE_W;
  localparam int DVD_W  = PROD_W;
  localparam int N_W    = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam int DVS_W  = POS_W;
  localparam int SPAN_W = POS_W + 1;
  // reciprocal of the sample count, exact for every sum below 2**SUM_W
  localparam int AVG_SH     = SUM_W + N_W;
  localparam int AVG_MUL    = ((1 << AVG_SH) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
  localparam int AVG_PROD_W = SUM_W + AVG_SH + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AVG   = 3'd1;
  localparam logic [2:0] ST_SIDE  = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_PCT   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]              state_q, state_d;
  logic                    axis_q;
  logic [SUM_W-1:0]        sum_q;
  logic [AVG_PROD_W-1:0]   avg_prod;
  logic [CAL_W-1:0]        avg_q;
  logic [DIST_W-1:0]       dist_q, dist_d;
  logic signed [SPAN_W-1:0] span_q, span_d;
  logic                    dir_q, dir_d;
  logic                    fault_q;
  logic [QSAT_W-1:0]       qsat_q;
  logic                    div_start;
  logic                    div_done;
  logic [DVD_W-1:0]        div_dvd;
  logic [DVS_W-1:0]        div_dvs;
  logic [DVD_W-1:0]        div_quo;
  logic [PROD_W-1:0]       prod;
  logic [DIV10_W-1:0]      round_mul;
  logic                    out_free;
  logic                    out_valid_q;
  logic                    out_axis_q;
  logic                    out_dir_q;
  logic [PCT_W-1:0]        out_pct_q;
  logic                    out_fault_q;

  jam_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // scaled distance for the span division
  assign prod = PROD_W'(dist_q) * PROD_W'(PCT_SCALE);

  // truncating average as a reciprocal multiply
  assign avg_prod = AVG_PROD_W'(sum_q) * AVG_PROD_W'(AVG_MUL);

  // the serial divider handles the span division only
  assign pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign div_start = (state_q == ST_START) && !fault_q;
  assign div_dvd   = prod;
  assign div_dvs   = span_q[POS_W-1:0];

  // side selection against the centre
  always_comb begin
    dir_d  = 1'b0;
    dist_d = '0;
    span_d = '0;
    if (axis_q == AXIS_LEFT) begin
      if (DIST_W'(avg_q) < DIST_W'(geom_i.left_center)) begin
        dir_d  = 1'b1;
        dist_d = DIST_W'(geom_i.left_center) - DIST_W'(avg_q);
        span_d = $signed({1'b0, geom_i.left_center}) - $signed({1'b0, geom_i.left_right_end});
      end else begin
        dist_d = DIST_W'(avg_q) - DIST_W'(geom_i.left_center);
        span_d = $signed({1'b0, geom_i.left_left_end}) - $signed({1'b0, geom_i.left_center});
      end
    end else begin
      if (DIST_W'(avg_q) > DIST_W'(geom_i.right_center)) begin
        dir_d  = 1'b1;
        dist_d = DIST_W'(avg_q) - DIST_W'(geom_i.right_center);
        span_d = $signed({1'b0, geom_i.right_back_end}) - $signed({1'b0, geom_i.right_center});
      end else begin
        dist_d = DIST_W'(geom_i.right_center) - DIST_W'(avg_q);
        span_d = $signed({1'b0, geom_i.right_center}) - $signed({1'b0, geom_i.right_front_end});
      end
    end
  end

  // sequencer
  assign out_free = !out_valid_q || out_ready_i;
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!q_empty_i) state_d = ST_AVG;
      ST_AVG:   state_d = ST_SIDE;
      ST_SIDE:  state_d = ST_START;
      ST_START: state_d = fault_q ? ST_FIN : ST_PCT;
      ST_PCT:   if (div_done) state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      axis_q <= q_data_i[SUM_W];
      sum_q  <= q_data_i[SUM_W-1:0];
    end
    if (state_q == ST_AVG) begin
      avg_q <= avg_prod[AVG_SH +: CAL_W];
    end
    if (state_q == ST_SIDE) begin
      dir_q   <= dir_d;
      dist_q  <= dist_d;
      span_q  <= span_d;
      fault_q <= span_d <= 0;
    end
    if (state_q == ST_START && fault_q) begin
      qsat_q <= QSAT_W'(QSAT_MAX);
    end
    if (state_q == ST_PCT && div_done) begin
      qsat_q <= (div_quo >= DVD_W'(QSAT_MAX)) ? QSAT_W'(QSAT_MAX) : div_quo[QSAT_W-1:0];
    end
  end

  // rounding divide by ten as a reciprocal multiply
  assign round_mul = DIV10_W'(qsat_q + QSAT_W'(ROUND_ADD)) * DIV10_W'(DIV10_MUL);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_axis_q  <= axis_q;
      out_dir_q   <= dir_q;
      out_pct_q   <= round_mul[DIV10_SHIFT +: PCT_W];
      out_fault_q <= fault_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_axis_o  = out_axis_q;
  assign out_dir_o   = out_dir_q;
  assign out_pct_o   = out_pct_q;
  assign out_fault_o = out_fault_q;

endmodule

FILE: design/joystick_axis_percent_mapper_top.sv
// top level of the joystick axis percentage mapper
//
//  channel   | direction | tdata / payload                       | tuser
//  s_axis    | in        | [11:0] raw_sample                     | axis
//  m_axis    | out       | [0] direction [7:1] percent [8] fault | axis_out
//  cfg       | in        | cfg_index_i register, cfg_data_i value | -
//
// an input sample is accepted whenever the queue is not full; the last of
// SAMPLES_PER_AVERAGE samples of an axis yields a result once the back end has
// averaged the sum, selected the side and run the serial span divider; a span
// fault skips the divider. a two-entry queue lets samples keep flowing meanwhile.
// reset clears accumulators, queue, sequencer and loads register defaults.
// the result waits in the output register while m_axis_tready is low.
module joystick_axis_percent_mapper_top import jam_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF,
  parameter int SAMPLE_FULL_SCALE   = SAMPLE_FULL_SCALE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // raw_sample in [11:0], zeros above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // axis
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // direction [0], percent [7:1], span_fault [8], zeros above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // axis_out
  output logic                   m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DAT_W-1:0]   cfg_data_i
);

  localparam int CAL_MAX = (SAMPLE_FULL_SCALE < CAL_LIMIT) ? SAMPLE_FULL_SCALE : CAL_LIMIT;
  localparam int CAL_W   = $clog2(CAL_MAX + 1);
  localparam int SUM_W   = $clog2(CAL_MAX * SAMPLES_PER_AVERAGE + 1);

  logic signed [OFFSET_W-1:0] offset_q;
  geom_t                      geom_q;
  logic                       push;
  logic [SUM_W:0]             push_data;
  logic                       pop;
  logic [SUM_W:0]             pop_data;
  logic                       q_full;
  logic                       q_empty;
  logic                       out_dir;
  logic [PCT_W-1:0]           out_pct;
  logic                       out_fault;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q               <= '0;
      geom_q.left_center     <= POS_W'(2048);
      geom_q.left_right_end  <= '0;
      geom_q.left_left_end   <= POS_W'(4095);
      geom_q.right_center    <= POS_W'(2048);
      geom_q.right_front_end <= '0;
      geom_q.right_back_end  <= POS_W'(4095);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CAL_OFFSET:      offset_q               <= cfg_data_i;
        REG_LEFT_CENTER:     geom_q.left_center     <= cfg_data_i[POS_W-1:0];
        REG_LEFT_RIGHT_END:  geom_q.left_right_end  <= cfg_data_i[POS_W-1:0];
        REG_LEFT_LEFT_END:   geom_q.left_left_end   <= cfg_data_i[POS_W-1:0];
        REG_RIGHT_CENTER:    geom_q.right_center    <= cfg_data_i[POS_W-1:0];
        REG_RIGHT_FRONT_END: geom_q.right_front_end <= cfg_data_i[POS_W-1:0];
        REG_RIGHT_BACK_END:  geom_q.right_back_end  <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  jam_front #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
    .SAMPLE_FULL_SCALE  (SAMPLE_FULL_SCALE),
    .CAL_W              (CAL_W),
    .SUM_W              (SUM_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_axis_i  (s_axis_tuser),
    .in_raw_i   (s_axis_tdata[RAW_W-1:0]),
    .in_ready_o (s_axis_tready),
    .offset_i   (offset_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  jam_queue #(
    .DATA_W(SUM_W + 1)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  jam_back #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
    .CAL_W              (CAL_W),
    .SUM_W              (SUM_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geom_i     (geom_q),
    .q_empty_i  (q_empty),
    .q_data_i   (pop_data),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_axis_o (m_axis_tuser),
    .out_dir_o  (out_dir),
    .out_pct_o  (out_pct),
    .out_fault_o(out_fault)
  );

  // pack result fields from the lowest bit up
  assign m_axis_tdata = {(OUT_TDATA_W - PCT_W - 2)'(0), out_fault, out_pct, out_dir};

endmodule

FILE: design/jam_checker.sv
// port-level checker for the joystick mapper and its bind
module jam_checker import jam_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready
);

  // percentage never exceeds full deflection
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] <= 7'd100)
    else $error("percent above 100");

  // a span fault always reports full deflection
  a_fault_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |-> m_axis_tdata[7:1] == 7'd100)
    else $error("span fault without 100 percent");

  // padding bits above the result stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:9] == '0)
    else $error("result padding not zero");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind joystick_axis_percent_mapper_top jam_checker u_jam_checker (.*);
